// File: rtl/scd_pkg.sv
// Shared types, constants and the month-length table for the calendar converter.
package scd_pkg;

  localparam int unsigned SECS_PER_DAY   = 86400;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned MINS_PER_HOUR  = 60;
  localparam int unsigned DAYS_PER_WEEK  = 7;
  localparam int unsigned EPOCH_WEEKDAY  = 6;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned LAST_MONTH_IDX = 11;
  localparam int unsigned YEAR_CAP       = 255;

  // A day is 128 times this many seconds.
  localparam int unsigned DAY_ODD = 675;

  // Rounded-up reciprocals: floor(x * RECIP / 2**SHIFT) equals the exact quotient
  // over each operand's full range, because the rounding error times the largest
  // operand stays below 2**SHIFT.
  localparam int unsigned DAY_RECIP         = 50903317;
  localparam int unsigned DAY_RECIP_SHIFT   = 35;
  localparam int unsigned MIN_RECIP         = 139811;
  localparam int unsigned MIN_RECIP_SHIFT   = 23;
  localparam int unsigned HOUR_RECIP        = 149131;
  localparam int unsigned HOUR_RECIP_SHIFT  = 29;
  localparam int unsigned WEEK_RECIP        = 74899;
  localparam int unsigned WEEK_RECIP_SHIFT  = 19;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_SPLIT_DAY,
    ST_DIV_TOD,
    ST_SPLIT_TOD,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_day;
    logic split_day;
    logic div_tod;
    logic split_tod;
    logic year_step;
    logic month_step;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  // Common-year length of month index 0 (January) through 11 (December).
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    unique case (mon)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/scd_ctrl.sv
// Sequencer that steps the datapath through divisions, the year walk and the month walk.
module scd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  scd_pkg::status_t  status,
  output scd_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              valid
);

  scd_pkg::state_t state;
  scd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    valid      = 1'b0;
    unique case (state)
      scd_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = scd_pkg::ST_DIV_DAY;
        end
      end
      scd_pkg::ST_DIV_DAY: begin
        cmd.div_day = 1'b1;
        state_next  = scd_pkg::ST_SPLIT_DAY;
      end
      scd_pkg::ST_SPLIT_DAY: begin
        cmd.split_day = 1'b1;
        state_next    = scd_pkg::ST_DIV_TOD;
      end
      scd_pkg::ST_DIV_TOD: begin
        cmd.div_tod = 1'b1;
        state_next  = scd_pkg::ST_SPLIT_TOD;
      end
      scd_pkg::ST_SPLIT_TOD: begin
        cmd.split_tod = 1'b1;
        state_next    = scd_pkg::ST_YEAR;
      end
      scd_pkg::ST_YEAR: begin
        if (status.year_done) begin
          state_next = scd_pkg::ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      scd_pkg::ST_MONTH: begin
        if (status.month_done) begin
          state_next = scd_pkg::ST_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      scd_pkg::ST_DONE: begin
        valid      = 1'b1;
        state_next = scd_pkg::ST_IDLE;
      end
      default: begin
        state_next = scd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/scd_datapath.sv
// Reciprocal dividers by constants, weekday residue, and year and month subtractors.
module scd_datapath (
  input  logic              clk,
  input  scd_pkg::cmd_t     cmd,
  input  logic [31:0]       epoch_seconds,
  output scd_pkg::status_t  status,
  output logic [7:0]        year_offset,
  output logic [3:0]        month,
  output logic [4:0]        day,
  output logic [2:0]        weekday,
  output logic [4:0]        hour,
  output logic [5:0]        minute,
  output logic [5:0]        second
);

  logic [31:0] seconds;
  logic [15:0] days;
  logic [16:0] tod;
  logic [10:0] mins;
  logic [12:0] weeks;
  logic [7:0]  year;
  logic [3:0]  mon;
  logic [5:0]  sec_r;
  logic [5:0]  min_r;
  logic [4:0]  hour_r;
  logic [2:0]  wday_r;

  logic [24:0] day_num;
  logic [50:0] day_prod;
  logic [24:0] day_low;
  logic [34:0] min_prod;
  logic [34:0] hour_prod;
  logic [15:0] wsum;
  logic [32:0] week_prod;
  logic [16:0] sec_full;
  logic [10:0] min_full;
  logic [15:0] wday_full;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  // A day is 128 * 675 seconds, so the low seven bits go straight into the time of day
  // and only the upper bits are divided by 675.
  assign day_num   = seconds[31:7];
  assign day_prod  = {26'd0, day_num} * 51'(scd_pkg::DAY_RECIP);
  assign day_low   = day_num - ({9'd0, days} * 25'(scd_pkg::DAY_ODD));

  assign min_prod  = {18'd0, tod} * 35'(scd_pkg::MIN_RECIP);
  assign hour_prod = {18'd0, tod} * 35'(scd_pkg::HOUR_RECIP);
  assign wsum      = days + 16'(scd_pkg::EPOCH_WEEKDAY);
  assign week_prod = {17'd0, wsum} * 33'(scd_pkg::WEEK_RECIP);

  assign sec_full  = tod - ({6'd0, mins} * 17'(scd_pkg::SECS_PER_MIN));
  assign min_full  = mins - ({6'd0, hour_r} * 11'(scd_pkg::MINS_PER_HOUR));
  assign wday_full = wsum - ({3'd0, weeks} * 16'(scd_pkg::DAYS_PER_WEEK));

  // Gregorian rule over the reachable span: 2100 and 2200 are common years.
  assign leap = (year[1:0] == 2'b00) && (year != 8'd100) && (year != 8'd200);
  assign ylen = 9'(scd_pkg::DAYS_PER_YEAR) + {8'd0, leap};
  assign mlen = scd_pkg::month_len(mon) + {4'd0, (leap && (mon == 4'd1))};

  assign status.year_done  = (days < {7'd0, ylen}) || (year == 8'(scd_pkg::YEAR_CAP));
  assign status.month_done = (mon == 4'(scd_pkg::LAST_MONTH_IDX)) || (days < {11'd0, mlen});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seconds <= epoch_seconds;
    end else if (cmd.div_day) begin
      days <= day_prod[scd_pkg::DAY_RECIP_SHIFT +: 16];
    end else if (cmd.split_day) begin
      tod <= {day_low[9:0], seconds[6:0]};
    end else if (cmd.div_tod) begin
      mins   <= min_prod[scd_pkg::MIN_RECIP_SHIFT +: 11];
      hour_r <= hour_prod[scd_pkg::HOUR_RECIP_SHIFT +: 5];
      weeks  <= week_prod[scd_pkg::WEEK_RECIP_SHIFT +: 13];
    end else if (cmd.split_tod) begin
      sec_r  <= sec_full[5:0];
      min_r  <= min_full[5:0];
      wday_r <= wday_full[2:0];
      year   <= '0;
      mon    <= '0;
    end else if (cmd.year_step) begin
      days <= days - {7'd0, ylen};
      year <= year + 8'd1;
    end else if (cmd.month_step) begin
      days <= days - {11'd0, mlen};
      mon  <= mon + 4'd1;
    end
  end

  assign year_offset = year;
  assign month       = mon + 4'd1;
  assign day         = days[4:0] + 5'd1;
  assign weekday     = wday_r;
  assign hour        = hour_r;
  assign minute      = min_r;
  assign second      = sec_r;

endmodule

// File: rtl/seconds_to_calendar.sv
// Top level: converts a count of seconds since 2000-01-01 into calendar date and time.
//
// Usage: drive epoch_seconds and raise start while busy is low; the beat is taken at
// that clock edge and busy rises on the next cycle. The result fields are shown for
// exactly one cycle with valid high; the receiver must take them then, it cannot stall.
// The fields hold their values until the next conversion starts updating them.
//
// The time from the accepting edge to the valid cycle grows with the year offset and
// the month index (0 to 11). The largest count falls in February of year offset 136,
// so the longest case is late December of offset 135. Four steps split the count with
// reciprocal multiplications by constants (days, then time of day and weekday);
// subtractors then walk the day count one year, then one month, per cycle. busy falls
// the cycle after valid, so the next beat can be taken in the cycle after the result
// is shown.
//
// A synchronous reset returns the sequencer to idle and drops any conversion in
// progress; no result appears for it.
module seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  output logic        valid,
  output logic [7:0]  year_offset,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [2:0]  weekday,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  scd_pkg::cmd_t    cmd;
  scd_pkg::status_t status;

  scd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .valid  (valid)
  );

  scd_datapath u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .epoch_seconds (epoch_seconds),
    .status        (status),
    .year_offset   (year_offset),
    .month         (month),
    .day           (day),
    .weekday       (weekday),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

  // An accepted beat keeps the block busy on the following cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // A result strobe lasts one cycle and the block is free right after it.
  a_valid_pulse: assert property (@(posedge clk) disable iff (rst)
    valid |=> (!valid && !busy))
    else $error("result strobe longer than one cycle or block stayed busy");

  // The strobe only appears while a conversion is in flight.
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> busy)
    else $error("result strobe while idle");

  // Every result field leaves the walks with a calendar-legal value.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> ((month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) &&
               (weekday <= 3'd6) && (hour <= 5'd23) && (minute <= 6'd59) &&
               (second <= 6'd59) && (year_offset <= 8'd136)))
    else $error("result field out of calendar range");

endmodule

// File: dv/seconds_to_calendar_test.sv
// Self-checking testbench for the seconds-to-calendar converter.
`timescale 1ns / 1ps

module seconds_to_calendar_test;

  localparam int unsigned WATCHDOG_LIMIT = 2400;
  localparam int unsigned SETTLE_CYCLES  = 250;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [7:0] year_offset;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } calendar_t;

  typedef struct {
    logic [31:0] epoch;
    calendar_t   date;
  } pending_date_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] epoch_seconds = '0;
  logic        busy;
  logic        valid;
  logic [7:0]  year_offset;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [2:0]  weekday;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  pending_date_t pending_dates[$];
  int unsigned   mismatches    = 0;
  int unsigned   dates_sent    = 0;
  int unsigned   dates_checked = 0;
  int unsigned   quiet_cycles  = 0;
  int unsigned   start_gap_pct = 0;

  seconds_to_calendar u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .epoch_seconds (epoch_seconds),
    .valid         (valid),
    .year_offset   (year_offset),
    .month         (month),
    .day           (day),
    .weekday       (weekday),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit is_leap_year(input int unsigned offset);
    int unsigned y;
    y = offset + 2000;
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned idx, input bit leap);
    int unsigned n;
    case (idx)
      1:             n = leap ? 29 : 28;
      3, 5, 8, 10:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  function automatic calendar_t calendar_of(input logic [31:0] t);
    int unsigned days;
    int unsigned tod;
    int unsigned yr;
    int unsigned mon;
    int unsigned ylen;
    bit          leap;
    calendar_t   c;
    days = t / scd_pkg::SECS_PER_DAY;
    tod  = t % scd_pkg::SECS_PER_DAY;
    c.second  = 6'(tod % 60);
    c.minute  = 6'((tod / 60) % 60);
    c.hour    = 5'(tod / 3600);
    c.weekday = 3'((days + scd_pkg::EPOCH_WEEKDAY) % scd_pkg::DAYS_PER_WEEK);
    yr   = 0;
    leap = is_leap_year(yr);
    ylen = leap ? 366 : 365;
    while (days >= ylen && yr < scd_pkg::YEAR_CAP) begin
      days = days - ylen;
      yr   = yr + 1;
      leap = is_leap_year(yr);
      ylen = leap ? 366 : 365;
    end
    mon = 0;
    while (mon < 11 && days >= month_days(mon, leap)) begin
      days = days - month_days(mon, leap);
      mon  = mon + 1;
    end
    c.year_offset = 8'(yr);
    c.month       = 4'(mon + 1);
    c.day         = 5'(days + 1);
    return c;
  endfunction

  task automatic check_field(input string name, input logic [31:0] t,
                             input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      if (mismatches < REPORT_LIMIT)
        $display("mismatch: epoch %0d %s expected %0d got %0d", t, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Results are checked before the new beat is queued, so a result and an
  // accept on the same edge cannot confuse the order.
  always @(posedge clk) begin
    pending_date_t exp_date;
    if (!rst) begin
      if (valid) begin
        if (pending_dates.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("mismatch: result with nothing outstanding, year %0d month %0d day %0d",
                     year_offset, month, day);
          mismatches++;
        end else begin
          exp_date = pending_dates.pop_front();
          check_field("year_offset", exp_date.epoch, exp_date.date.year_offset, year_offset);
          check_field("month", exp_date.epoch, 8'(exp_date.date.month), 8'(month));
          check_field("day", exp_date.epoch, 8'(exp_date.date.day), 8'(day));
          check_field("weekday", exp_date.epoch, 8'(exp_date.date.weekday), 8'(weekday));
          check_field("hour", exp_date.epoch, 8'(exp_date.date.hour), 8'(hour));
          check_field("minute", exp_date.epoch, 8'(exp_date.date.minute), 8'(minute));
          check_field("second", exp_date.epoch, 8'(exp_date.date.second), 8'(second));
          dates_checked++;
        end
      end
      if (start && !busy) begin
        exp_date.epoch = epoch_seconds;
        exp_date.date  = calendar_of(epoch_seconds);
        pending_dates.push_back(exp_date);
        dates_sent++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat and no result for %0d cycles", quiet_cycles);
        $display("seconds_to_calendar_test: errors");
        $finish;
      end
    end
  end

  // Holds the beat until an edge with busy low takes it, then maybe leaves a gap.
  task automatic send_epoch(input logic [31:0] t);
    int unsigned gap;
    start         <= 1'b1;
    epoch_seconds <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(99) < start_gap_pct) begin
      gap = $urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 260);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] random_epoch();
    int unsigned d;
    logic [31:0] t;
    d = $urandom_range(49709);
    case ($urandom_range(3))
      0, 1:    t = $urandom;
      2:       t = d * scd_pkg::SECS_PER_DAY + $urandom_range(2);
      default: t = d * scd_pkg::SECS_PER_DAY + 86397 + $urandom_range(2);
    endcase
    return t;
  endfunction

  task automatic run_random_dates(input int unsigned count);
    repeat (count) send_epoch(random_epoch());
  endtask

  task automatic test_edge_dates();
    start_gap_pct = 0;
    send_epoch(32'd0);
    send_epoch(32'hFFFF_FFFF);
    send_epoch(32'h7FFF_FFFF);
    send_epoch(32'h8000_0000);
    send_epoch(32'd59);
    send_epoch(32'd60);
    send_epoch(32'd3599);
    send_epoch(32'd3600);
    send_epoch(32'd86399);
    send_epoch(32'd86400);
    // Leap day of 2000, a year divisible by 400.
    send_epoch(32'd59 * 86400);
    send_epoch(32'd60 * 86400 - 1);
    send_epoch(32'd60 * 86400);
    // Last second of 2000 and first of 2001.
    send_epoch(32'd366 * 86400 - 1);
    send_epoch(32'd366 * 86400);
    // Leap day of 2096.
    send_epoch(32'd35123 * 86400);
    // 2100 is divisible by 100 but not by 400, so February ends on the 28th.
    send_epoch(32'd36525 * 86400 - 1);
    send_epoch(32'd36525 * 86400);
    send_epoch(32'd36583 * 86400 + 86399);
    send_epoch(32'd36584 * 86400);
    send_epoch(32'hAAAA_AAAA);
    send_epoch(32'h5555_5555);
    drain_results();
  endtask

  task automatic test_back_to_back();
    start_gap_pct = 0;
    run_random_dates(560);
    drain_results();
  endtask

  task automatic test_sparse_starts();
    start_gap_pct = 74;
    run_random_dates(560);
    drain_results();
  endtask

  task automatic test_mixed_gaps();
    start_gap_pct = 28;
    run_random_dates(280);
    // Let the converter empty out completely before carrying on.
    drain_results();
    run_random_dates(280);
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_dates();
    test_back_to_back();
    test_sparse_starts();
    test_mixed_gaps();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_dates.size() != 0) begin
      $display("%0d conversions never produced a result", pending_dates.size());
      mismatches++;
    end
    $display("covered %0d conversions (%0d checked): leap days, year ends, both count ends,",
             dates_sent, dates_checked);
    $display("then random times with start gaps of 0, 74 and 28 percent; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("seconds_to_calendar_test: clean");
    end else begin
      $display("seconds_to_calendar_test: errors");
    end
    $finish;
  end

endmodule
